/* design/sha2_pkg.sv */
// Shared types, constants and round functions for the SHA-256/SHA-224 engine.
package sha2_pkg;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_END  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] LAST_POS    = 6'h3F;
    localparam logic [2:0] LAST_IDX_256 = 3'd7;
    localparam logic [2:0] LAST_IDX_224 = 3'd6;

    localparam logic [31:0] IV_256 [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] IV_224 [8] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return g ^ (e & (f ^ g));
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) | (c & (a | b));
    endfunction

endpackage

/* design/sha2_front.sv */
// Front end: accepts input requests, drops empty ones, splits byte-with-end into two commands.
module sha2_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_message_byte,
    input  logic           s_byte_present,
    input  logic           s_end_of_message,
    output logic           push_valid,
    input  logic           push_ready,
    output sha2_pkg::cmd_t push_cmd
);

    logic pend_reg;
    logic pend_next;
    logic take;

    assign s_ready = !pend_reg && push_ready;
    assign take    = s_valid && s_ready;

    assign push_valid    = pend_reg || (take && (s_byte_present || s_end_of_message));
    assign push_cmd.kind = (pend_reg || !s_byte_present) ? sha2_pkg::CMD_END
                                                        : sha2_pkg::CMD_BYTE;
    assign push_cmd.data = s_message_byte;

    always_comb begin
        pend_next = pend_reg;
        if (pend_reg && push_ready) begin
            pend_next = 1'b0;
        end else if (take && s_byte_present && s_end_of_message) begin
            // hold the end mark until the byte has gone in
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
        end
    end

endmodule

/* design/sha2_cmd_queue.sv */
// Short command queue between the front end and the hash engine.
module sha2_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  sha2_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sha2_pkg::cmd_t pop_cmd
);

    sha2_pkg::cmd_t                 mem_reg [sha2_pkg::QUEUE_DEPTH];
    logic [sha2_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sha2_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sha2_pkg::QCNT_W-1:0]    count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != sha2_pkg::QCNT_W'(sha2_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* design/sha2_back.sv */
// Hash engine: block packing, padding, 64-round compression and digest output.
module sha2_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  sha2_pkg::cmd_t cmd,
    input  logic           cfg_write,
    input  logic           cfg_mode_224,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [31:0]    m_digest_word,
    output logic [2:0]     m_word_index,
    output logic           m_last_word
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PAD    = 5'b00010,
        ST_ROUND  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE = 2'd0,
        RET_PAD  = 2'd1,
        RET_OUT  = 2'd2
    } ret_t;

    state_t       state_reg, state_next;
    ret_t         ret_reg, ret_next;
    logic         mode_reg;
    logic [31:0]  chain_reg [8];
    logic [31:0]  w_reg     [16];
    logic [31:0]  var_reg   [8];
    logic [63:0]  count_reg;
    logic [5:0]   round_reg;
    logic [5:0]   pad_pos_reg;
    logic [2:0]   out_idx_reg;
    logic         out_valid_reg;
    logic [31:0]  out_word_reg;
    logic [2:0]   out_index_reg;
    logic         out_last_reg;

    logic         put_en;
    logic [5:0]   put_pos;
    logic [7:0]   put_byte;
    logic [31:0]  put_old;
    logic [31:0]  put_word;
    logic         len_write;
    logic         start_block;
    logic         take_cmd;
    logic         out_load;
    logic         finish;
    logic [2:0]   last_idx;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  sched_new;

    assign cmd_ready     = (state_reg == ST_IDLE);
    assign take_cmd      = cmd_valid && cmd_ready;
    assign last_idx      = mode_reg ? sha2_pkg::LAST_IDX_224 : sha2_pkg::LAST_IDX_256;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_ready);
    assign finish        = out_load && (out_idx_reg == last_idx);

    assign m_valid       = out_valid_reg;
    assign m_digest_word = out_word_reg;
    assign m_word_index  = out_index_reg;
    assign m_last_word   = out_last_reg;

    // merge one byte into its big-endian slot
    always_comb begin
        put_old = w_reg[put_pos[5:2]];
        case (put_pos[1:0])
            2'd0:    put_word = {put_byte, 24'h0};
            2'd1:    put_word = {put_old[31:24], put_byte, 16'h0};
            2'd2:    put_word = {put_old[31:16], put_byte, 8'h0};
            default: put_word = {put_old[31:8], put_byte};
        endcase
    end

    always_comb begin
        t1 = var_reg[7] + sha2_pkg::bsig1(var_reg[4])
           + sha2_pkg::choose(var_reg[4], var_reg[5], var_reg[6])
           + sha2_pkg::K_TABLE[round_reg] + w_reg[0];
        t2 = sha2_pkg::bsig0(var_reg[0]) + sha2_pkg::majority(var_reg[0], var_reg[1], var_reg[2]);
        sched_new = sha2_pkg::ssig1(w_reg[14]) + w_reg[9] + sha2_pkg::ssig0(w_reg[1]) + w_reg[0];
    end

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        put_en      = 1'b0;
        put_pos     = count_reg[5:0];
        put_byte    = cmd.data;
        len_write   = 1'b0;
        start_block = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (take_cmd) begin
                    put_en   = 1'b1;
                    put_byte = (cmd.kind == sha2_pkg::CMD_BYTE) ? cmd.data : sha2_pkg::PAD_BYTE;
                    if (count_reg[5:0] == sha2_pkg::LAST_POS) begin
                        start_block = 1'b1;
                        ret_next    = (cmd.kind == sha2_pkg::CMD_BYTE) ? RET_IDLE : RET_PAD;
                        state_next  = ST_ROUND;
                    end else if (cmd.kind == sha2_pkg::CMD_END) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (pad_pos_reg == sha2_pkg::LEN_POS) begin
                    len_write   = 1'b1;
                    start_block = 1'b1;
                    ret_next    = RET_OUT;
                    state_next  = ST_ROUND;
                end else begin
                    put_en   = 1'b1;
                    put_pos  = pad_pos_reg;
                    put_byte = 8'h00;
                    if (pad_pos_reg == sha2_pkg::LAST_POS) begin
                        start_block = 1'b1;
                        ret_next    = RET_PAD;
                        state_next  = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                if (round_reg == sha2_pkg::LAST_POS) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                case (ret_reg)
                    RET_IDLE: state_next = ST_IDLE;
                    RET_PAD:  state_next = ST_PAD;
                    default:  state_next = ST_OUT;
                endcase
            end
            ST_OUT: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // block window, round variables and output word
    always_ff @(posedge aclk) begin
        if (put_en) begin
            w_reg[put_pos[5:2]] <= put_word;
        end
        if (len_write) begin
            w_reg[14] <= count_reg[60:29];
            w_reg[15] <= {count_reg[28:0], 3'b000};
        end
        if (start_block) begin
            for (int i = 0; i < 8; i++) begin
                var_reg[i] <= chain_reg[i];
            end
        end
        if (state_reg == ST_ROUND) begin
            // slide the schedule window by one word
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15]  <= sched_new;
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
        if (out_load) begin
            out_word_reg  <= chain_reg[out_idx_reg];
            out_index_reg <= out_idx_reg;
            out_last_reg  <= (out_idx_reg == last_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_IDLE;
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            round_reg     <= '0;
            pad_pos_reg   <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= sha2_pkg::IV_256[i];
            end
        end else if (cfg_write) begin
            // restart the engine in the new mode
            state_reg   <= ST_IDLE;
            mode_reg    <= cfg_mode_224;
            count_reg   <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= cfg_mode_224 ? sha2_pkg::IV_224[i] : sha2_pkg::IV_256[i];
            end
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (take_cmd && (cmd.kind == sha2_pkg::CMD_BYTE)) begin
                count_reg <= count_reg + 64'd1;
            end
            if (take_cmd && (cmd.kind == sha2_pkg::CMD_END)) begin
                pad_pos_reg <= count_reg[5:0] + 6'd1;
            end else if (put_en && (state_reg == ST_PAD)) begin
                pad_pos_reg <= pad_pos_reg + 6'd1;
            end
            if (start_block) begin
                round_reg <= '0;
            end else if (state_reg == ST_ROUND) begin
                round_reg <= round_reg + 6'd1;
            end
            if (state_reg == ST_UPDATE) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (finish) begin
                // last word is loaded into the output register: reload initial values for the next message
                out_idx_reg <= '0;
                count_reg   <= '0;
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= mode_reg ? sha2_pkg::IV_224[i] : sha2_pkg::IV_256[i];
                end
            end else if (out_load) begin
                out_idx_reg <= out_idx_reg + 3'd1;
            end
        end
    end

endmodule

/* design/sha256_sha224_hash.sv */
// Top level of the streaming SHA-256/SHA-224 hash engine.
//
//  channel  dir  handshake            payload
//  s_       in   s_valid / s_ready    s_message_byte, s_byte_present, s_end_of_message
//  m_       out  m_valid / m_ready    m_digest_word, m_word_index, m_last_word
//  cfg_     in   cfg_valid / cfg_ready cfg_mode_224
//
// A byte is packed into the block window; the byte that fills a block adds 64 rounds
// and one chaining update. An end mark pads one zero byte per cycle up to offset 56,
// then compresses (one or two blocks) and emits 8 or 7 words, one per cycle unless the output stalls.
// Reset (aresetn, synchronous) selects SHA-256; a mode write restarts the message.
// A four-entry command queue lets input run ahead while padding, the rounds or a
// stalled result hold the engine; the output register holds a word until m_ready.
module sha256_sha224_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_message_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_mode_224
);

    logic           push_valid;
    logic           push_ready;
    sha2_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    sha2_pkg::cmd_t pop_cmd;

    assign cfg_ready = 1'b1;

    sha2_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_message_byte   (s_message_byte),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_cmd         (push_cmd)
    );

    sha2_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    sha2_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (pop_valid),
        .cmd_ready     (pop_ready),
        .cmd           (pop_cmd),
        .cfg_write     (cfg_valid),
        .cfg_mode_224  (cfg_mode_224),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

endmodule
